FILE: design/dirty_line_writeback_buffer_macros.svh
// ----------------------------------------------------------------------------
// Dirty-line write-back buffer assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DIRTY_LINE_WRITEBACK_BUFFER_MACROS_SVH
`define DIRTY_LINE_WRITEBACK_BUFFER_MACROS_SVH
`ifndef SYNTH
`define DLWB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DLWB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DLWB_ASSERT(lbl, clk, rst, prop, msg)
`define DLWB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: design/dlwb_pkg.sv
// ----------------------------------------------------------------------------
// Dirty-line write-back buffer package
// Shared constants, operation codes, state encoding and interface structs.
// ----------------------------------------------------------------------------
package dlwb_pkg;

  localparam int STORE_BYTES      = 4096;
  localparam int ADDR_W           = 12;
  localparam int RUN_CAP          = 8;
  localparam int LINE_SHIFT_DEF   = 9;
  localparam int NUM_LINES_DEF    = 8;
  localparam logic [3:0] MAX_RUN_RESET = 4'd1;

  typedef enum logic [2:0] {
    FUNC_READ  = 3'd0,
    FUNC_WRITE = 3'd1,
    FUNC_LOAD  = 3'd2,
    FUNC_TICK  = 3'd3,
    FUNC_FAIL  = 3'd4
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    func_t              func;
    logic               changed;
    logic [ADDR_W-1:0]  address;
    logic [2:0]         fail_start;
    logic [3:0]         fail_count;
  } dirty_cmd_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] start;
    logic [3:0] count;
  } flush_t;

endpackage

FILE: design/dlwb_store.sv
// ----------------------------------------------------------------------------
// Byte store
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dlwb_store
  import dlwb_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data
);

  logic [7:0] mem [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/dlwb_dirty.sv
// ----------------------------------------------------------------------------
// Dirty line tracker
// Holds the dirty mask and the run limit, marks lines of changed writes,
// finds flush runs and re-marks failed runs.
// ----------------------------------------------------------------------------
module dlwb_dirty
  import dlwb_pkg::*;
#(
  parameter int LINE_SHIFT = LINE_SHIFT_DEF,
  parameter int NUM_LINES  = NUM_LINES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_value,
  input  logic                 apply,
  input  dirty_cmd_t           cmd,
  output flush_t               flush,
  output logic [NUM_LINES-1:0] mask_after
);

  localparam int LW    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int EXT_W = NUM_LINES + RUN_CAP;

  logic [NUM_LINES-1:0] mask;
  logic [3:0]           max_run;
  logic [LW-1:0]        first_line;
  logic [LW-1:0]        lowest;
  logic                 any_dirty;
  logic [3:0]           limit;
  logic [EXT_W-1:0]     ext;
  logic [3:0]           run;
  logic                 cont;
  logic [3:0]           fail_cnt;
  logic [ADDR_W-1:0]    line;
  logic [LW+2:0]        start_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask    <= '0;
      max_run <= MAX_RUN_RESET;
    end else begin
      if (apply) begin
        mask <= mask_after;
      end
      if (cfg_we) begin
        max_run <= cfg_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    first_line <= lowest;
  end

  always_comb begin
    lowest = '0;
    for (int j = NUM_LINES - 1; j >= 0; j--) begin
      if (mask[j]) begin
        lowest = LW'(j);
      end
    end
  end

  assign any_dirty = |mask;
  assign line      = cmd.address >> LINE_SHIFT;

  always_comb begin
    if (max_run == 4'd0) begin
      limit = 4'd1;
    end else if (max_run > 4'(RUN_CAP)) begin
      limit = 4'(RUN_CAP);
    end else begin
      limit = max_run;
    end
    ext  = {{RUN_CAP{1'b0}}, mask} >> first_line;
    run  = 4'd1;
    cont = 1'b1;
    for (int k = 1; k < RUN_CAP; k++) begin
      if (cont && (4'(k) < limit) && ext[k]) begin
        run = run + 4'd1;
      end else begin
        cont = 1'b0;
      end
    end
    fail_cnt  = (cmd.fail_count > 4'(RUN_CAP)) ? 4'(RUN_CAP) : cmd.fail_count;
    start_ext = {3'b000, first_line};
  end

  always_comb begin
    mask_after = mask;
    flush      = '0;
    case (cmd.func)
      FUNC_WRITE: begin
        for (int j = 0; j < NUM_LINES; j++) begin
          if (cmd.changed && (line == ADDR_W'(j))) begin
            mask_after[j] = 1'b1;
          end
        end
      end
      FUNC_TICK: begin
        if (any_dirty) begin
          for (int j = 0; j < NUM_LINES; j++) begin
            if ((j >= int'(first_line)) && (j < int'(first_line) + int'(run))) begin
              mask_after[j] = 1'b0;
            end
          end
          flush.valid = 1'b1;
          flush.start = start_ext[2:0];
          flush.count = run;
        end
      end
      FUNC_FAIL: begin
        for (int j = 0; j < NUM_LINES; j++) begin
          if ((j >= int'(cmd.fail_start)) &&
              (j < int'(cmd.fail_start) + int'(fail_cnt))) begin
            mask_after[j] = 1'b1;
          end
        end
      end
      default: begin
        mask_after = mask;
      end
    endcase
  end

endmodule

FILE: design/dirty_line_writeback_buffer.sv
// ----------------------------------------------------------------------------
// Dirty-line write-back buffer: byte store with per-line dirty tracking
// Result: registered when execution ends; a stalled result holds execution.
// Items: one at a time; the next waits for the store read then write.
// Reset: synchronous; clears the dirty mask, sets the run limit to one.
// ----------------------------------------------------------------------------
`include "dirty_line_writeback_buffer_macros.svh"

module dirty_line_writeback_buffer
  import dlwb_pkg::*;
#(
  parameter int LINE_SHIFT = LINE_SHIFT_DEF,
  parameter int NUM_LINES  = NUM_LINES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  func,
  input  logic [11:0] address,
  input  logic [7:0]  data,
  input  logic        last_of_block,
  input  logic [2:0]  fail_start_line,
  input  logic [3:0]  fail_line_count,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  read_data,
  output logic        flush_valid,
  output logic [2:0]  flush_start_line,
  output logic [3:0]  flush_line_count,
  output logic [7:0]  dirty_lines_now
);

  state_t               state;
  state_t               state_next;
  logic                 accept;
  logic                 apply;
  logic                 out_free;
  func_t                func_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [7:0]           data_q;
  logic [2:0]           fail_start_q;
  logic [3:0]           fail_count_q;
  logic [7:0]           rd_data;
  logic                 changed;
  logic                 mem_we;
  dirty_cmd_t           cmd;
  flush_t               flush;
  logic [NUM_LINES-1:0] mask_after;
  logic [NUM_LINES+7:0] mask_ext;
  logic                 exec;
  logic                 count_ok;

  assign cfg_ready  = !rst;
  assign item_stall = rst || (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    apply      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          apply      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q       <= func_t'(func);
      addr_q       <= address;
      data_q       <= data;
      fail_start_q <= fail_start_line;
      fail_count_q <= fail_line_count;
    end
  end

  dlwb_store u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (address),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (addr_q),
    .wr_data (data_q)
  );

  assign changed = (rd_data != data_q);
  assign mem_we  = apply && (((func_q == FUNC_WRITE) && changed) || (func_q == FUNC_LOAD));

  always_comb begin
    cmd.func       = func_q;
    cmd.changed    = changed;
    cmd.address    = addr_q;
    cmd.fail_start = fail_start_q;
    cmd.fail_count = fail_count_q;
  end

  dlwb_dirty #(
    .LINE_SHIFT (LINE_SHIFT),
    .NUM_LINES  (NUM_LINES)
  ) u_dirty (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_value  (cfg_data),
    .apply      (apply),
    .cmd        (cmd),
    .flush      (flush),
    .mask_after (mask_after)
  );

  assign mask_ext = {8'h00, mask_after};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (apply) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      read_data        <= (func_q == FUNC_READ) ? rd_data : 8'h00;
      flush_valid      <= flush.valid;
      flush_start_line <= flush.start;
      flush_line_count <= flush.count;
      dirty_lines_now  <= mask_ext[7:0];
    end
  end

  assign exec     = (state == ST_EXEC);
  assign count_ok = (flush_line_count != 4'd0) && (flush_line_count <= 4'd8);

  `DLWB_ASSERT(a_accept_to_exec, clk, rst, accept |=> exec, "transfer not executed")
  `DLWB_ASSERT(a_result_after_exec, clk, rst, $rose(result_valid) |-> $past(exec), "stray result")
  `DLWB_ASSERT(a_flush_count, clk, rst, (result_valid && flush_valid) |-> count_ok, "bad count")
  `DLWB_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!result_valid && !exec), "reset not applied")

endmodule

FILE: sim/dirty_line_writeback_buffer_test.sv
// ----------------------------------------------------------------------------
// Dirty-line write-back buffer testbench
// Drives byte loads, reads, writes, flush ticks and flush failures through
// the item channel and predicts every result in a scoreboard that holds its
// own copy of the byte store, the dirty mask and the run limit. Directed
// items cover the corner cases first, then random traffic runs under several
// run limits and idle patterns, including a long result hold-off.
// ----------------------------------------------------------------------------
module dirty_line_writeback_buffer_test
  import dlwb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 330;
  localparam int HOLD_ITEMS    = 40;
  localparam int HOLD_CYCLES   = 150;
  localparam int MAX_REPORTS   = 200;
  localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [2:0]  func;
    logic [11:0] address;
    logic [7:0]  data;
    logic        last_of_block;
    logic [2:0]  fail_start_line;
    logic [3:0]  fail_line_count;
  } item_t;

  typedef struct {
    logic [7:0] read_data;
    logic       flush_valid;
    logic [2:0] flush_start_line;
    logic [3:0] flush_line_count;
    logic [7:0] dirty_lines_now;
  } result_t;

  class writeback_tracker;
    logic [7:0]               bytes [STORE_BYTES];
    bit                       filled [STORE_BYTES];
    int unsigned              filled_list [$];
    logic [NUM_LINES_DEF-1:0] dirty;
    logic [3:0]               run_limit;
    result_t                  awaited [$];
    int unsigned              errors;
    int unsigned              results_seen;
    int unsigned              flushes;
    int unsigned              func_seen [8];

    function new();
      dirty = '0;
      run_limit = MAX_RUN_RESET;
      errors = 0;
      results_seen = 0;
      flushes = 0;
      foreach (func_seen[i]) func_seen[i] = 0;
    endfunction

    function void mark_line(int unsigned ln);
      if (ln < NUM_LINES_DEF) dirty[ln] = 1'b1;
    endfunction

    function void remember(logic [11:0] addr, logic [7:0] value);
      bytes[addr] = value;
      if (!filled[addr]) begin
        filled[addr] = 1'b1;
        filled_list.push_back(addr);
      end
    endfunction

    function result_t compute_result(item_t it);
      result_t r;
      int unsigned first, n, lim, cnt;
      r = '{default: '0};
      case (it.func)
        FUNC_READ: r.read_data = bytes[it.address];
        FUNC_WRITE: begin
          if (bytes[it.address] !== it.data) begin
            remember(it.address, it.data);
            mark_line(it.address >> LINE_SHIFT_DEF);
          end
        end
        FUNC_LOAD: remember(it.address, it.data);
        FUNC_TICK: begin
          first = NUM_LINES_DEF;
          for (int i = NUM_LINES_DEF - 1; i >= 0; i--) begin
            if (dirty[i]) first = i;
          end
          if (first < NUM_LINES_DEF) begin
            lim = (run_limit == 0) ? 1 : (run_limit > RUN_CAP) ? RUN_CAP : run_limit;
            n = 1;
            while (n < lim && first + n < NUM_LINES_DEF && dirty[first + n]) n++;
            for (int k = 0; k < n; k++) dirty[first + k] = 1'b0;
            r.flush_valid = 1'b1;
            r.flush_start_line = 3'(first);
            r.flush_line_count = 4'(n);
          end
        end
        FUNC_FAIL: begin
          cnt = (it.fail_line_count > RUN_CAP) ? RUN_CAP : it.fail_line_count;
          for (int k = 0; k < cnt; k++) mark_line(int'(it.fail_start_line) + k);
        end
        default: ;
      endcase
      r.dirty_lines_now = dirty;
      return r;
    endfunction

    function void note_item(item_t it);
      func_seen[it.func]++;
      awaited.push_back(compute_result(it));
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [7:0] rd, logic fv, logic [2:0] fs, logic [3:0] fc,
                               logic [7:0] dl);
      result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no transfer awaiting it, expected none, actual mask %0h",
                   $time, dl);
        return;
      end
      want = awaited.pop_front();
      if (want.flush_valid) flushes++;
      compare("read_data", want.read_data, rd);
      compare("flush_valid", 8'(want.flush_valid), 8'(fv));
      compare("flush_start_line", 8'(want.flush_start_line), 8'(fs));
      compare("flush_line_count", 8'(want.flush_line_count), 8'(fc));
      compare("dirty_lines_now", want.dirty_lines_now, dl);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [2:0]  func = FUNC_READ;
  logic [11:0] address = '0;
  logic [7:0]  data = '0;
  logic        last_of_block = 1'b0;
  logic [2:0]  fail_start_line = '0;
  logic [3:0]  fail_line_count = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  read_data;
  logic        flush_valid;
  logic [2:0]  flush_start_line;
  logic [3:0]  flush_line_count;
  logic [7:0]  dirty_lines_now;

  writeback_tracker tracker = new();
  int unsigned send_gap_pct = 20;
  int unsigned recv_stall_pct = 71;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned limit_writes = 0;

  dirty_line_writeback_buffer u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .func             (func),
    .address          (address),
    .data             (data),
    .last_of_block    (last_of_block),
    .fail_start_line  (fail_start_line),
    .fail_line_count  (fail_line_count),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .read_data        (read_data),
    .flush_valid      (flush_valid),
    .flush_start_line (flush_start_line),
    .flush_line_count (flush_line_count),
    .dirty_lines_now  (dirty_lines_now)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      result_stall <= 1'b1;
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      tracker.check_result(read_data, flush_valid, flush_start_line, flush_line_count,
                           dirty_lines_now);
  end

  task automatic send_item(input item_t it);
    if ($urandom_range(99) < send_gap_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    item_valid      <= 1'b1;
    func            <= it.func;
    address         <= it.address;
    data            <= it.data;
    last_of_block   <= it.last_of_block;
    fail_start_line <= it.fail_start_line;
    fail_line_count <= it.fail_line_count;
    do @(posedge clk); while (item_stall);
    tracker.note_item(it);
  endtask

  task automatic send_fields(input logic [2:0] f, input logic [11:0] addr,
                             input logic [7:0] value, input logic [2:0] fs,
                             input logic [3:0] fc, input logic lob);
    item_t it;
    it = '{func: f, address: addr, data: value, last_of_block: lob,
           fail_start_line: fs, fail_line_count: fc};
    send_item(it);
  endtask

  task automatic wait_for_results();
    item_valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_run_limit(input logic [3:0] limit);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.run_limit = limit;
    limit_writes++;
  endtask

  function automatic item_t random_item();
    item_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    it.func = FUNC_LOAD;
    it.address = 12'($urandom);
    it.data = 8'($urandom);
    it.last_of_block = 1'($urandom);
    it.fail_start_line = 3'($urandom);
    it.fail_line_count = ($urandom_range(9) == 0) ? 4'($urandom)
                                                  : 4'($urandom_range(RUN_CAP, 1));
    if (pick >= 20 && pick < 63 && tracker.filled_list.size() == 0) pick = 0;
    if (pick < 20) begin
      it.func = FUNC_LOAD;
    end else if (pick < 63) begin
      it.address = 12'(tracker.filled_list[$urandom_range(tracker.filled_list.size() - 1)]);
      if (pick < 45) begin
        it.func = FUNC_WRITE;
        if ($urandom_range(99) < 40) it.data = tracker.bytes[it.address];
      end else begin
        it.func = FUNC_READ;
      end
    end else if (pick < 81) begin
      it.func = FUNC_TICK;
    end else if (pick < 93) begin
      it.func = FUNC_FAIL;
    end else begin
      it.func = 3'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST));
    end
    return it;
  endfunction

  initial begin
    logic [3:0] limits [6];
    int unsigned phase, n;
    limits = '{4'd8, 4'd3, 4'd15, 4'd0, 4'd5, 4'd1};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_run_limit(MAX_RUN_RESET);
    send_fields(FUNC_LOAD, 12'h000, 8'h00, 3'd0, 4'd0, 1'b0);
    send_fields(FUNC_LOAD, 12'hFFF, 8'hFF, 3'd7, 4'd15, 1'b1);
    send_fields(FUNC_LOAD, 12'h555, 8'hAA, 3'd0, 4'd0, 1'b0);
    send_fields(FUNC_LOAD, 12'hAAA, 8'h55, 3'd0, 4'd0, 1'b1);
    send_fields(FUNC_READ, 12'h000, 8'h00, 3'd0, 4'd0, 1'b0);
    send_fields(FUNC_READ, 12'hFFF, 8'h00, 3'd0, 4'd0, 1'b1);
    send_fields(FUNC_WRITE, 12'h000, 8'h00, 3'd0, 4'd0, 1'b0);
    send_fields(FUNC_WRITE, 12'h000, 8'hFF, 3'd0, 4'd0, 1'b0);
    send_fields(FUNC_WRITE, 12'hFFF, 8'h00, 3'd0, 4'd0, 1'b0);
    send_fields(FUNC_WRITE, 12'hAAA, 8'h55, 3'd0, 4'd0, 1'b1);
    send_fields(FUNC_TICK, 12'h000, 8'h00, 3'd0, 4'd0, 1'b0);
    send_fields(FUNC_TICK, 12'h000, 8'h00, 3'd0, 4'd0, 1'b0);
    send_fields(FUNC_TICK, 12'h000, 8'h00, 3'd0, 4'd0, 1'b0);
    send_fields(FUNC_FAIL, 12'h000, 8'h00, 3'd0, 4'd0, 1'b0);
    send_fields(FUNC_FAIL, 12'h000, 8'h00, 3'd6, 4'd15, 1'b0);
    send_fields(FUNC_FAIL, 12'h000, 8'h00, 3'd0, 4'd8, 1'b0);
    send_fields(FUNC_TICK, 12'h000, 8'h00, 3'd0, 4'd0, 1'b0);
    send_fields(FUNC_SPARE_FIRST, 12'hFFF, 8'hFF, 3'd7, 4'd8, 1'b1);
    send_fields(FUNC_SPARE_FIRST + 3'd1, 12'h000, 8'h00, 3'd0, 4'd8, 1'b0);
    send_fields(FUNC_SPARE_LAST, 12'hFFF, 8'hFF, 3'd7, 4'd15, 1'b1);
    send_fields(FUNC_READ, 12'h555, 8'h00, 3'd0, 4'd0, 1'b0);
    send_fields(FUNC_READ, 12'hAAA, 8'h00, 3'd0, 4'd0, 1'b1);
    wait_for_results();

    write_run_limit(4'd8);
    send_fields(FUNC_TICK, 12'h000, 8'h00, 3'd0, 4'd0, 1'b0);
    send_fields(FUNC_FAIL, 12'h000, 8'h00, 3'd2, 4'd3, 1'b0);
    send_fields(FUNC_FAIL, 12'h000, 8'h00, 3'd6, 4'd2, 1'b0);
    send_fields(FUNC_TICK, 12'h000, 8'h00, 3'd0, 4'd0, 1'b0);
    send_fields(FUNC_TICK, 12'h000, 8'h00, 3'd0, 4'd0, 1'b0);

    for (phase = 0; phase < 6; phase++) begin
      send_gap_pct   = (phase < 2) ? 20 : (phase < 4) ? 71 : 0;
      recv_stall_pct = (phase < 2) ? 71 : (phase < 4) ? 20 : 0;
      wait_for_results();
      write_run_limit(limits[phase]);
      if (phase == 4) begin
        hold_asked++;
        for (n = 0; n < HOLD_ITEMS; n++) send_item(random_item());
        wait_for_results();
      end
      for (n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
    end
    wait_for_results();

    $display("Covered %0d reads, %0d writes, %0d loads, %0d ticks, %0d flush failures,",
             tracker.func_seen[FUNC_READ], tracker.func_seen[FUNC_WRITE],
             tracker.func_seen[FUNC_LOAD], tracker.func_seen[FUNC_TICK],
             tracker.func_seen[FUNC_FAIL]);
    $display("%0d results with %0d flush commands, over %0d run limit writes; %0d errors.",
             tracker.results_seen, tracker.flushes, limit_writes, tracker.errors);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
